// ----- hdl/alt_pkg.sv -----
// shared types, byte codes and result codes for the array literal tokenizer
package alt_pkg;

    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_QUOTE  = 8'h22;

    localparam logic [1:0] KIND_BYTE   = 2'd0;
    localparam logic [1:0] KIND_END    = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;

    localparam logic [1:0] ST_START  = 2'd0;
    localparam logic [1:0] ST_PLAIN  = 2'd1;
    localparam logic [1:0] ST_QUOTED = 2'd2;
    localparam logic [1:0] ST_ESC    = 2'd3;

    localparam logic [2:0] MATCH_FULL = 3'd4;
    localparam logic [2:0] MATCH_FAIL = 3'd5;

    typedef struct packed {
        logic [7:0] ch;
        logic       final_byte;
    } t_in;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data_byte;
        logic       is_null;
        logic       ok;
        logic       run_last;
    } t_out;

    function automatic logic [7:0] null_char(input logic [1:0] idx);
        logic [7:0] c;
        case (idx)
            2'd0:    c = 8'h4E;
            2'd1:    c = 8'h55;
            default: c = 8'h4C;
        endcase
        return c;
    endfunction

endpackage

// ----- hdl/alt_scan.sv -----
// tokenizer state and the per-byte result logic
module alt_scan
    import alt_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  t_in        i_beat,
    output logic [1:0] o_cnt,
    output t_out       o_res0,
    output t_out       o_res1
);

    logic [1:0] r_position, n_position;
    logic       r_open,     n_open;
    logic [1:0] r_scan,     n_scan;
    logic [1:0] r_resume,   n_resume;
    logic       r_qclosed,  n_qclosed;
    logic [2:0] r_nmatch,   n_nmatch;

    logic       do_content;
    logic       okv;
    logic [7:0] c;

    always_comb begin
        n_position = r_position;
        n_open     = r_open;
        n_scan     = r_scan;
        n_resume   = r_resume;
        n_qclosed  = r_qclosed;
        n_nmatch   = r_nmatch;
        o_cnt      = 2'd0;
        o_res0     = '0;
        o_res1     = '0;
        do_content = 1'b0;
        okv        = 1'b0;
        c          = i_beat.ch;

        if (!i_beat.final_byte) begin
            if (r_position == 2'd0) begin
                n_open     = (c == CH_LBRACE);
                n_position = 2'd1;
            end else begin
                n_position = 2'd2;
                if (c == CH_COMMA) begin
                    case (r_scan)
                        ST_START: begin
                            o_res0.kind    = KIND_END;
                            o_res0.is_null = 1'b1;
                            o_cnt          = 2'd1;
                        end
                        ST_PLAIN: begin
                            o_res0.kind    = KIND_END;
                            o_res0.is_null = (r_nmatch == MATCH_FULL);
                            o_cnt          = 2'd1;
                            n_scan         = ST_START;
                        end
                        ST_QUOTED: begin
                            do_content = 1'b1;
                        end
                        default: begin
                            n_scan     = r_resume;
                            do_content = 1'b1;
                        end
                    endcase
                end else if (c == CH_BSLASH) begin
                    if (r_scan == ST_START) begin
                        n_qclosed = 1'b0;
                        n_nmatch  = 3'd0;
                        n_resume  = ST_PLAIN;
                        n_scan    = ST_ESC;
                    end else if (r_scan != ST_ESC) begin
                        n_resume = r_scan;
                        n_scan   = ST_ESC;
                    end
                    do_content = 1'b1;
                end else if (c == CH_QUOTE) begin
                    case (r_scan)
                        ST_START: begin
                            n_qclosed = 1'b0;
                            n_nmatch  = 3'd0;
                            n_scan    = ST_QUOTED;
                        end
                        ST_PLAIN: begin
                            do_content = 1'b1;
                        end
                        ST_ESC: begin
                            n_scan     = r_resume;
                            do_content = 1'b1;
                        end
                        default: begin
                            n_qclosed = 1'b1;
                            n_scan    = ST_PLAIN;
                        end
                    endcase
                end else begin
                    if (r_scan == ST_START) begin
                        n_qclosed = 1'b0;
                        n_nmatch  = 3'd0;
                        n_scan    = ST_PLAIN;
                    end else if (r_scan == ST_ESC) begin
                        n_scan = r_resume;
                    end
                    do_content = 1'b1;
                end

                if (do_content && !n_qclosed) begin
                    if (n_nmatch < MATCH_FULL && c == null_char(n_nmatch[1:0])) begin
                        n_nmatch = n_nmatch + 3'd1;
                    end else begin
                        n_nmatch = MATCH_FAIL;
                    end
                    o_res0.kind      = KIND_BYTE;
                    o_res0.data_byte = c;
                    o_cnt            = 2'd1;
                end
            end
        end else begin
            case (r_position)
                2'd0:    okv = 1'b0;
                2'd1:    okv = 1'b1;
                default: okv = r_open && (c == CH_RBRACE);
            endcase
            if (r_position == 2'd2 && okv && r_scan == ST_PLAIN) begin
                o_res0.kind    = KIND_END;
                o_res0.is_null = (r_nmatch == MATCH_FULL);
                o_res1.kind    = KIND_STATUS;
                o_res1.ok      = okv;
                o_cnt          = 2'd2;
            end else begin
                o_res0.kind = KIND_STATUS;
                o_res0.ok   = okv;
                o_cnt       = 2'd1;
            end
            n_position = 2'd0;
            n_open     = 1'b0;
            n_scan     = ST_START;
            n_resume   = ST_START;
            n_qclosed  = 1'b0;
            n_nmatch   = 3'd0;
        end

        if (o_cnt == 2'd2) begin
            o_res1.run_last = 1'b1;
        end else if (o_cnt == 2'd1) begin
            o_res0.run_last = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_position <= 2'd0;
            r_open     <= 1'b0;
            r_scan     <= ST_START;
            r_resume   <= ST_START;
            r_qclosed  <= 1'b0;
            r_nmatch   <= 3'd0;
        end else if (i_step) begin
            r_position <= n_position;
            r_open     <= n_open;
            r_scan     <= n_scan;
            r_resume   <= n_resume;
            r_qclosed  <= n_qclosed;
            r_nmatch   <= n_nmatch;
        end
    end

endmodule

// ----- hdl/alt_fifo.sv -----
// result queue taking up to two results per cycle and giving one per cycle while i_ready is high
module alt_fifo
    import alt_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [1:0] i_push_cnt,
    input  t_out       i_res0,
    input  t_out       i_res1,
    output logic       o_room,
    output logic       o_valid,
    input  logic       i_ready,
    output t_out       o_data
);

    t_out             r_mem [FIFO_DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_count, n_count;
    logic             pop;

    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd];
    assign o_room  = (r_count <= CNT_W'(FIFO_DEPTH - 2));
    assign pop     = o_valid && i_ready;

    always_comb begin
        n_wr    = r_wr + PTR_W'(i_push_cnt);
        n_rd    = r_rd + PTR_W'(pop);
        n_count = r_count + CNT_W'(i_push_cnt) - CNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push_cnt != 2'd0) begin
            r_mem[r_wr] <= i_res0;
        end
        if (i_push_cnt == 2'd2) begin
            r_mem[r_wr + PTR_W'(1)] <= i_res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

endmodule

// ----- hdl/array_literal_tokenizer.sv -----
// top level: input register, tokenizer step and result queue
// a byte waits in the input register until the queue has room; one byte per cycle
// while the queue has room; results leave one per cycle while i_out_ready is high;
// a closing byte that ends an element and the literal gives two results
// reset: synchronous active low, clears tokenizer state and empties the queue
module array_literal_tokenizer
    import alt_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out
);

    logic       r_in_vld;
    t_in        r_in;
    logic       room;
    logic       step;
    logic [1:0] cnt;
    logic [1:0] push_cnt;
    t_out       res0;
    t_out       res1;

    assign step       = r_in_vld && room;
    assign o_in_ready = !r_in_vld || room;
    assign push_cnt   = step ? cnt : 2'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            r_in_vld <= 1'b1;
        end else if (step) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in;
        end
    end

    alt_scan u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_beat  (r_in),
        .o_cnt   (cnt),
        .o_res0  (res0),
        .o_res1  (res1)
    );

    alt_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push_cnt (push_cnt),
        .i_res0     (res0),
        .i_res1     (res1),
        .o_room     (room),
        .o_valid    (o_out_valid),
        .i_ready    (i_out_ready),
        .o_data     (o_out)
    );

`ifndef SYNTHESIS
    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.kind == KIND_STATUS |-> o_out.run_last)
        else $error("status beat without run_last");

    a_pair_is_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step && cnt == 2'd2 |-> res0.kind == KIND_END && res1.kind == KIND_STATUS)
        else $error("two results that are not element end then status");

    a_final_reports: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step && r_in.final_byte |-> cnt != 2'd0)
        else $error("final beat gave no status");

    a_stall_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> r_in_vld && !room)
        else $error("input stalled with no held beat");
`endif

endmodule

// ----- dv/testbench.sv -----
// testbench for the array literal tokenizer: directed and random literals, scoreboard with a byte-level predictor
`timescale 1ns / 100ps

module testbench;
    import alt_pkg::*;

    typedef logic [7:0] t_bytes [$];

    localparam logic [31:0] NULL_WORD = "NULL";

    logic i_clk;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_ready;
    t_in  i_in;
    logic o_out_valid;
    logic i_out_ready;
    t_out o_out;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_left     = 0;
    int beats_sent    = 0;

    class tokenizer_scoreboard;
        logic [1:0] position;
        logic       open_seen;
        logic [1:0] scan;
        logic [1:0] resume;
        logic       closed;
        logic [2:0] null_cnt;
        t_out       pending [$];
        t_out       step_res [$];
        int         errors;

        function new();
            clear();
            errors = 0;
        endfunction

        function void clear();
            position  = 2'd0;
            open_seen = 1'b0;
            scan      = ST_START;
            resume    = ST_START;
            closed    = 1'b0;
            null_cnt  = 3'd0;
        endfunction

        function void emit(logic [1:0] kind, logic [7:0] data, logic nul_flag, logic okv);
            t_out r;
            r = '0;
            r.kind      = kind;
            r.data_byte = data;
            r.is_null   = nul_flag;
            r.ok        = okv;
            step_res.push_back(r);
        endfunction

        function void take_content(logic [7:0] c);
            if (closed) return;
            if (null_cnt < MATCH_FULL && c == NULL_WORD[31 - 8 * int'(null_cnt[1:0]) -: 8])
                null_cnt = null_cnt + 3'd1;
            else
                null_cnt = MATCH_FAIL;
            emit(KIND_BYTE, c, 1'b0, 1'b0);
        endfunction

        function void scan_interior(logic [7:0] c);
            if (c == CH_COMMA) begin
                case (scan)
                    ST_START: begin
                        emit(KIND_END, 8'h00, 1'b1, 1'b0);
                    end
                    ST_PLAIN: begin
                        emit(KIND_END, 8'h00, null_cnt == MATCH_FULL, 1'b0);
                        scan = ST_START;
                    end
                    ST_QUOTED: begin
                        take_content(c);
                    end
                    default: begin
                        scan = resume;
                        take_content(c);
                    end
                endcase
            end else if (c == CH_BSLASH) begin
                if (scan == ST_START) begin
                    closed   = 1'b0;
                    null_cnt = 3'd0;
                    resume   = ST_PLAIN;
                    scan     = ST_ESC;
                end else if (scan != ST_ESC) begin
                    resume = scan;
                    scan   = ST_ESC;
                end
                take_content(c);
            end else if (c == CH_QUOTE) begin
                case (scan)
                    ST_START: begin
                        closed   = 1'b0;
                        null_cnt = 3'd0;
                        scan     = ST_QUOTED;
                    end
                    ST_PLAIN: begin
                        take_content(c);
                    end
                    ST_ESC: begin
                        scan = resume;
                        take_content(c);
                    end
                    default: begin
                        closed = 1'b1;
                        scan   = ST_PLAIN;
                    end
                endcase
            end else begin
                if (scan == ST_START) begin
                    closed   = 1'b0;
                    null_cnt = 3'd0;
                    scan     = ST_PLAIN;
                end else if (scan == ST_ESC) begin
                    scan = resume;
                end
                take_content(c);
            end
        endfunction

        function void note_byte(t_in beat);
            logic okv;
            t_out last;
            step_res.delete();
            if (!beat.final_byte) begin
                if (position == 2'd0) begin
                    open_seen = (beat.ch == CH_LBRACE);
                    position  = 2'd1;
                end else begin
                    scan_interior(beat.ch);
                    position = 2'd2;
                end
            end else begin
                if (position == 2'd0) begin
                    okv = 1'b0;
                end else if (position == 2'd1) begin
                    okv = 1'b1;
                end else begin
                    okv = open_seen && beat.ch == CH_RBRACE;
                    if (okv && scan == ST_PLAIN)
                        emit(KIND_END, 8'h00, null_cnt == MATCH_FULL, 1'b0);
                end
                emit(KIND_STATUS, 8'h00, 1'b0, okv);
                clear();
            end
            if (step_res.size() > 0) begin
                last = step_res.pop_back();
                last.run_last = 1'b1;
                step_res.push_back(last);
            end
            foreach (step_res[i]) pending.push_back(step_res[i]);
        endfunction

        function void check_field(string name, int unsigned want, int unsigned seen);
            if (want != seen) begin
                $display("%0t: %s expected %0h actual %0h", $time, name, want, seen);
                errors++;
            end
        endfunction

        function void check_result(t_out got);
            t_out want;
            if (pending.size() == 0) begin
                $display("%0t: result %h with nothing expected", $time, got);
                errors++;
                return;
            end
            want = pending.pop_front();
            check_field("kind", want.kind, got.kind);
            check_field("data_byte", want.data_byte, got.data_byte);
            check_field("is_null", want.is_null, got.is_null);
            check_field("ok", want.ok, got.ok);
            check_field("run_last", want.run_last, got.run_last);
        endfunction
    endclass

    tokenizer_scoreboard sb = new();

    array_literal_tokenizer uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (hold_left > 0) begin
                i_out_ready <= 1'b0;
                hold_left = hold_left - 1;
            end else begin
                i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_result(o_out);
    end

    task automatic send_byte(input t_in beat);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= beat;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_byte(beat);
        beats_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_literal(input t_bytes lit);
        t_in beat;
        foreach (lit[i]) begin
            beat.ch         = lit[i];
            beat.final_byte = (i == lit.size() - 1);
            send_byte(beat);
        end
    endtask

    function automatic void add_text(ref t_bytes q, input string s);
        for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
    endfunction

    function automatic logic [7:0] plain_char();
        case ($urandom_range(5))
            0: return "N";
            1: return "U";
            2: return "L";
            3: return 8'($urandom_range(8'h30, 8'h39));
            default: return 8'($urandom_range(8'h61, 8'h7A));
        endcase
    endfunction

    function automatic logic [7:0] quoted_char();
        logic [7:0] c;
        do c = 8'($urandom_range(255)); while (c == CH_QUOTE || c == CH_BSLASH);
        return c;
    endfunction

    function automatic void add_element(ref t_bytes q);
        int n;
        n = $urandom_range(1, 4);
        case ($urandom_range(9))
            0: begin
            end
            1: begin
                add_text(q, "NULL");
            end
            2: begin
                add_text(q, "\"NULL\"");
            end
            3: begin
                add_text(q, "\"\"");
            end
            4: begin
                repeat (n) q.push_back(plain_char());
            end
            5: begin
                q.push_back(CH_QUOTE);
                repeat (n) begin
                    case ($urandom_range(3))
                        0: begin
                            q.push_back(CH_BSLASH);
                            case ($urandom_range(3))
                                0: q.push_back(CH_QUOTE);
                                1: q.push_back(CH_BSLASH);
                                2: q.push_back(CH_COMMA);
                                default: q.push_back(quoted_char());
                            endcase
                        end
                        1: q.push_back(CH_COMMA);
                        default: q.push_back(quoted_char());
                    endcase
                end
                q.push_back(CH_QUOTE);
            end
            6: begin
                q.push_back(CH_BSLASH);
                if ($urandom_range(1)) q.push_back(CH_BSLASH);
                else q.push_back(8'($urandom_range(255)));
                repeat (n - 1) q.push_back(plain_char());
            end
            7: begin
                q.push_back(CH_QUOTE);
                q.push_back(plain_char());
                q.push_back(CH_QUOTE);
                repeat (n) q.push_back(plain_char());
            end
            8: begin
                q.push_back(plain_char());
                q.push_back(CH_QUOTE);
                q.push_back(plain_char());
                q.push_back(CH_BSLASH);
                q.push_back(CH_BSLASH);
                q.push_back(plain_char());
            end
            default: begin
                case ($urandom_range(3))
                    0: add_text(q, "NUL");
                    1: add_text(q, "NULLX");
                    2: add_text(q, "nULL");
                    default: add_text(q, "\\NULL");
                endcase
            end
        endcase
    endfunction

    function automatic void make_well_formed(ref t_bytes q);
        int n;
        n = $urandom_range(0, 4);
        q.push_back(CH_LBRACE);
        for (int i = 0; i < n; i++) begin
            if (i > 0) q.push_back(CH_COMMA);
            add_element(q);
        end
        q.push_back(CH_RBRACE);
    endfunction

    function automatic void make_broken(ref t_bytes q);
        case ($urandom_range(6))
            0: begin
                repeat ($urandom_range(1, 6)) q.push_back(8'($urandom_range(255)));
            end
            1: begin
                q.push_back(8'($urandom_range(255)));
            end
            2: begin
                repeat (2) q.push_back(8'($urandom_range(255)));
            end
            3: begin
                make_well_formed(q);
                q[0] = 8'($urandom_range(255));
            end
            4: begin
                make_well_formed(q);
                q[q.size() - 1] = 8'($urandom_range(255));
            end
            5: begin
                add_text(q, "{\"x");
                q.push_back(plain_char());
                q.push_back(CH_RBRACE);
            end
            default: begin
                add_text(q, "{a\\}");
            end
        endcase
    endfunction

    task automatic run_random(input int upto);
        t_bytes lit;
        while (beats_sent < upto) begin
            lit = {};
            if ($urandom_range(99) < 80) make_well_formed(lit);
            else make_broken(lit);
            send_literal(lit);
        end
    endtask

    initial begin
        t_bytes lit;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in        = '0;
        i_out_ready = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 27;
        recv_idle_pct = 59;
        lit = {};
        add_text(lit, "{");
        send_literal(lit);
        lit = {};
        add_text(lit, "ab");
        send_literal(lit);
        lit = {};
        add_text(lit, "{NULL,\"\",,\\\"x}");
        send_literal(lit);
        lit = {};
        add_text(lit, "{\"a,\"z}");
        send_literal(lit);
        lit = {8'h00, 8'hFF, CH_RBRACE};
        send_literal(lit);
        run_random(360);

        send_idle_pct = 59;
        recv_idle_pct = 27;
        hold_left     = 80;
        run_random(690);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_left     = 80;
        run_random(1020);
        i_in_valid <= 1'b0;

        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
